// ----- rtl/core/drlw_pkg.sv -----
// shared types, codes and command constants of the lcd nibble writer
`default_nettype none

package drlw_pkg;

  typedef enum logic {
    OpInit = 1'b0,
    OpShow = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SettleShort = 2'd0,
    SettleLong  = 2'd1,
    SettleClear = 2'd2
  } settle_e;

  typedef enum logic [2:0] {
    FrIdle = 3'b001,
    FrConv = 3'b010,
    FrPush = 3'b100
  } front_state_e;

  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] RegCursorAddr = 3'd0;

  localparam logic [7:0] CmdFunctionSet = 8'h28;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdEntryMode   = 8'h06;
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdSetDdram    = 8'h80;
  localparam logic [7:0] AsciiZero      = 8'h30;

  localparam int unsigned InitBytes = 4;

  function automatic logic [7:0] setup_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      2'd0:    cmd = CmdFunctionSet;
      2'd1:    cmd = CmdDisplayOn;
      2'd2:    cmd = CmdEntryMode;
      default: cmd = CmdClear;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/decimal_reading_lcd_nibble_writer_top.sv -----
// top level of the 4-bit lcd writer: register port, front end, queue, sequencer
//
// channel   dir  beat contents
// s_*       in   tdata: opcode[0], sample[SAMPLE_BITS:1]
// m_*       out  tdata: nibble[3:0], settle_class[5:4]; tuser: register_select; tlast
// apb       in   cursor_address at byte address 0
//
// an init beat gives 8 nibble beats, a show beat 2+2*DIGITS, one per cycle from the sequencer
// while m_tready is not stalled; the front end converts the sample of a show beat to bcd,
// overlapped with output of the previous entry
// reset clears handshake state and cursor_address, no clearing pass
// a stalled m_tready holds the output register; the queue then fills and s_tready drops
`default_nettype none

module decimal_reading_lcd_nibble_writer_top #(
  parameter int unsigned DIGITS      = 4,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_tvalid,
  output      logic                                   s_tready,
  // opcode, sample
  input  wire logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] s_tdata,
  output      logic                                   m_tvalid,
  input  wire logic                                   m_tready,
  // nibble, settle_class
  output      logic [7:0]                             m_tdata,
  // register_select
  output      logic                                   m_tuser,
  output      logic                                   m_tlast,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [drlw_pkg::AddrW-1:0]             paddr,
  input  wire logic [31:0]                            pwdata,
  output      logic [31:0]                            prdata,
  output      logic                                   pready
);
  import drlw_pkg::*;

  localparam int unsigned BcdW = 4 * DIGITS;

  logic [6:0]      cursor_q;
  logic            fr_valid, fr_ready;
  op_e             fr_op;
  logic [BcdW-1:0] fr_bcd;
  logic            q_valid, q_ready;
  logic [BcdW:0]   q_data;
  op_e             q_op;
  settle_e         settle;
  logic [3:0]      nibble;
  op_e             in_op;

  assign pready = 1'b1;
  assign prdata = (paddr == RegCursorAddr) ? {25'd0, cursor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == RegCursorAddr)) begin
      cursor_q <= pwdata[6:0];
    end
  end

  assign in_op = op_e'(s_tdata[0]);

  drlw_front #(
    .DIGITS      (DIGITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_op_i     (in_op),
    .in_sample_i (s_tdata[SAMPLE_BITS:1]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_op_o    (fr_op),
    .out_bcd_o   (fr_bcd)
  );

  drlw_fifo #(
    .WIDTH (BcdW + 1)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   ({fr_bcd, fr_op}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign q_op = op_e'(q_data[0]);

  drlw_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_op_i      (q_op),
    .in_bcd_i     (q_data[BcdW:1]),
    .cursor_i     (cursor_q),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_rs_o     (m_tuser),
    .out_nibble_o (nibble),
    .out_settle_o (settle),
    .out_last_o   (m_tlast)
  );

  assign m_tdata = {2'b00, settle, nibble};

endmodule

`default_nettype wire

// ----- rtl/core/drlw_front.sv -----
// front end: takes input beats and converts the sample of a show beat to bcd one bit per cycle
`default_nettype none

module drlw_front #(
  parameter int unsigned DIGITS      = 4,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire drlw_pkg::op_e            in_op_i,
  input  wire logic [SAMPLE_BITS-1:0]   in_sample_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      drlw_pkg::op_e            out_op_o,
  output      logic [4*DIGITS-1:0]      out_bcd_o
);
  import drlw_pkg::*;

  localparam int unsigned BcdW = 4 * DIGITS;
  localparam int unsigned CntW = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

  front_state_e           state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  op_e                    op_q, op_d;
  logic                   accept;

  // one double-dabble step: correct each digit, then shift in the next bit
  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] bcd, input logic b);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], b};
  endfunction

  assign in_ready_o  = (state_q == FrIdle) || ((state_q == FrPush) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == FrPush);
  assign out_op_o    = op_q;
  assign out_bcd_o   = bcd_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bcd_d   = bcd_q;
    shift_d = shift_q;
    op_d    = op_q;
    unique case (state_q)
      FrIdle: begin
      end
      FrConv: begin
        bcd_d   = dabble(bcd_q, shift_q[SAMPLE_BITS-1]);
        shift_d = shift_q << 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(SAMPLE_BITS - 1)) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        if (out_ready_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
    if (accept) begin
      op_d    = in_op_i;
      bcd_d   = BcdW'(in_sample_i[SAMPLE_BITS-1]);
      shift_d = in_sample_i << 1;
      cnt_d   = CntW'(1);
      state_d = ((in_op_i == OpShow) && (SAMPLE_BITS > 1)) ? FrConv : FrPush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    shift_q <= shift_d;
    op_q    <= op_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/drlw_fifo.sv -----
// two-entry queue between front end and nibble sequencer
`default_nettype none

module drlw_fifo #(
  parameter int unsigned WIDTH = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/drlw_back.sv -----
// back end: walks the bytes of one entry and sends one nibble beat per cycle while the output is not stalled
`default_nettype none

module drlw_back #(
  parameter int unsigned DIGITS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire drlw_pkg::op_e       in_op_i,
  input  wire logic [4*DIGITS-1:0] in_bcd_i,
  input  wire logic [6:0]          cursor_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                out_rs_o,
  output      logic [3:0]          out_nibble_o,
  output      drlw_pkg::settle_e   out_settle_o,
  output      logic                out_last_o
);
  import drlw_pkg::*;

  localparam int unsigned BcdW       = 4 * DIGITS;
  localparam int unsigned NumNibShow = 2 + 2 * DIGITS;
  localparam int unsigned NumNibInit = 2 * InitBytes;
  localparam int unsigned NibMax     = (NumNibShow > NumNibInit) ? NumNibShow : NumNibInit;
  localparam int unsigned NibW       = $clog2(NibMax);
  localparam int unsigned ByteW      = NibW - 1;

  logic            cur_vld_q, cur_vld_d;
  op_e             cur_op_q, cur_op_d;
  logic [BcdW-1:0] cur_bcd_q, cur_bcd_d;
  logic [NibW-1:0] cnt_q, cnt_d;

  logic            m_valid_q, m_valid_d;
  logic            m_rs_q, m_rs_d;
  logic [3:0]      m_nib_q, m_nib_d;
  settle_e         m_settle_q, m_settle_d;
  logic            m_last_q, m_last_d;

  logic             out_free, emit, is_last, finish, pop;
  logic [ByteW-1:0] byte_idx;
  logic [3:0]       digit;
  logic [7:0]       cur_byte;

  assign out_free   = !m_valid_q || out_ready_i;
  assign emit       = cur_vld_q && out_free;
  assign is_last    = (cur_op_q == OpShow) ? (cnt_q == NibW'(NumNibShow - 1))
                                           : (cnt_q == NibW'(NumNibInit - 1));
  assign finish     = emit && is_last;
  assign in_ready_o = !cur_vld_q || finish;
  assign pop        = in_valid_i && in_ready_o;
  assign byte_idx   = cnt_q[NibW-1:1];

  always_comb begin
    digit = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (byte_idx == ByteW'(DIGITS - i)) begin
        digit = cur_bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    if (cur_op_q == OpInit) begin
      cur_byte = setup_cmd(byte_idx[1:0]);
    end else if (byte_idx == '0) begin
      cur_byte = CmdSetDdram | {1'b0, cursor_i};
    end else begin
      cur_byte = AsciiZero | {4'b0000, digit};
    end
  end

  always_comb begin
    cur_vld_d  = cur_vld_q;
    cur_op_d   = cur_op_q;
    cur_bcd_d  = cur_bcd_q;
    cnt_d      = cnt_q;
    m_valid_d  = m_valid_q;
    m_rs_d     = m_rs_q;
    m_nib_d    = m_nib_q;
    m_settle_d = m_settle_q;
    m_last_d   = m_last_q;
    if (out_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (emit) begin
      m_valid_d = 1'b1;
      m_rs_d    = (cur_op_q == OpShow) && (byte_idx != '0);
      m_nib_d   = cnt_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      m_last_d  = is_last;
      if (!cnt_q[0]) begin
        m_settle_d = SettleShort;
      end else if ((cur_op_q == OpInit) && (byte_idx == ByteW'(InitBytes - 1))) begin
        m_settle_d = SettleClear;
      end else begin
        m_settle_d = SettleLong;
      end
      cnt_d = is_last ? '0 : cnt_q + 1'b1;
    end
    if (finish) begin
      cur_vld_d = 1'b0;
    end
    if (pop) begin
      cur_vld_d = 1'b1;
      cur_op_d  = in_op_i;
      cur_bcd_d = in_bcd_i;
      cnt_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_op_q   <= cur_op_d;
    cur_bcd_q  <= cur_bcd_d;
    m_rs_q     <= m_rs_d;
    m_nib_q    <= m_nib_d;
    m_settle_q <= m_settle_d;
    m_last_q   <= m_last_d;
  end

  assign out_valid_o  = m_valid_q;
  assign out_rs_o     = m_rs_q;
  assign out_nibble_o = m_nib_q;
  assign out_settle_o = m_settle_q;
  assign out_last_o   = m_last_q;

  a_init_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_vld_q && (cur_op_q == OpInit)) |-> (cnt_q <= NibW'(NumNibInit - 1)))
    else $error("init nibble count past end of sequence");

  a_last_on_low_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q) |-> (m_settle_q != SettleShort))
    else $error("last beat is not a low half");

  a_entry_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !is_last) |=> cur_vld_q)
    else $error("entry dropped before its last nibble");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for the 4-bit lcd nibble writer: setup and digit sequences, cursor register
`timescale 1ns / 100ps

module testbench;

  import drlw_pkg::*;

  localparam int unsigned Digits     = 4;
  localparam int unsigned SampleBits = 10;
  localparam int unsigned SDataW     = ((SampleBits + 8) / 8) * 8;
  localparam int unsigned DrainWait  = 24;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintLimit = 40;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    settle_e    settle;
    logic       last;
  } lcd_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid;
  logic              s_tready;
  logic [SDataW-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lcd_beat_t   pending_beats[$];
  lcd_beat_t   want;
  logic [6:0]  cursor_addr;
  int unsigned mismatches;
  int unsigned cycles;
  bit          steady;

  decimal_reading_lcd_nibble_writer_top #(
    .DIGITS      (Digits),
    .SAMPLE_BITS (SampleBits)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    if (mismatches < PrintLimit) begin
      $display("[%0t] %s: got %0d, wanted %0d", $realtime, what, got, exp_v);
    end
    mismatches++;
  endtask

  function automatic void queue_byte(input logic rs, input logic [7:0] byte_v,
                                     input settle_e low_settle);
    lcd_beat_t hi;
    lcd_beat_t lo;
    hi.rs     = rs;
    hi.nib    = byte_v[7:4];
    hi.settle = SettleShort;
    hi.last   = 1'b0;
    lo.rs     = rs;
    lo.nib    = byte_v[3:0];
    lo.settle = low_settle;
    lo.last   = 1'b0;
    pending_beats.push_back(hi);
    pending_beats.push_back(lo);
  endfunction

  function automatic void predict_lcd_beats(input op_e op, input logic [SampleBits-1:0] sample);
    logic [7:0]  setup_list[4];
    int unsigned place;
    int unsigned digit;
    lcd_beat_t   tail;
    setup_list = '{CmdFunctionSet, CmdDisplayOn, CmdEntryMode, CmdClear};
    if (op == OpInit) begin
      foreach (setup_list[i]) begin
        queue_byte(1'b0, setup_list[i], (setup_list[i] == CmdClear) ? SettleClear : SettleLong);
      end
    end else begin
      queue_byte(1'b0, CmdSetDdram | {1'b0, cursor_addr}, SettleLong);
      place = 1;
      for (int i = 1; i < Digits; i++) place *= 10;
      for (int i = 0; i < Digits; i++) begin
        digit = (int'(sample) / place) % 10;
        queue_byte(1'b1, AsciiZero + 8'(digit), SettleLong);
        place = (place / 10 == 0) ? 1 : place / 10;
      end
    end
    tail = pending_beats.pop_back();
    tail.last = 1'b1;
    pending_beats.push_back(tail);
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_item(input op_e op, input logic [SampleBits-1:0] sample);
    while (!steady && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDataW'({sample, op});
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_lcd_beats(op, sample);
    @(negedge clk_i);
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == (AddrW'(RegCursorAddr) << 2)) cursor_addr = data[6:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_check_cursor;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(RegCursorAddr) << 2;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== {25'b0, cursor_addr}) begin
      report_mismatch("cursor readback", int'(got), int'(cursor_addr));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_setup_sequence;
    send_item(OpInit, '0);
    send_item(OpInit, '1);
    send_item(OpInit, 10'h2AA);
    wait_drained();
  endtask

  task automatic test_sample_extremes;
    logic [SampleBits-1:0] picks[12];
    picks = '{10'd0, 10'd1023, 10'd999, 10'd1000, 10'd9, 10'd10,
              10'd99, 10'd100, 10'd341, 10'd682, 10'd512, 10'd1};
    foreach (picks[i]) send_item(OpShow, picks[i]);
    wait_drained();
  endtask

  task automatic test_cursor_address;
    apb_write(AddrW'(RegCursorAddr) << 2, 32'hFFFF_FFFF);
    apb_check_cursor();
    send_item(OpShow, 10'd507);
    wait_drained();
    apb_write(AddrW'(RegCursorAddr) << 2, 32'h0000_0055);
    apb_check_cursor();
    send_item(OpShow, 10'd42);
    wait_drained();
    // unmapped register, must leave the cursor untouched
    apb_write(AddrW'(4), 32'h0000_0033);
    apb_check_cursor();
    send_item(OpShow, 10'd808);
    wait_drained();
    apb_write(AddrW'(RegCursorAddr) << 2, 32'hAAAA_AA2A);
    apb_check_cursor();
    send_item(OpShow, 10'd3);
    wait_drained();
    apb_write(AddrW'(RegCursorAddr) << 2, 32'h0);
    apb_check_cursor();
  endtask

  task automatic random_burst(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        send_item(OpInit, SampleBits'($urandom));
      end else if ($urandom_range(9) == 0) begin
        send_item(OpShow, $urandom_range(1) ? '1 : '0);
      end else begin
        send_item(OpShow, SampleBits'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic;
    logic [6:0] settings[3];
    settings = '{7'h7F, 7'($urandom), 7'h00};
    foreach (settings[p]) begin
      apb_write(AddrW'(RegCursorAddr) << 2, {25'($urandom), 7'b0} | 32'(settings[p]));
      random_burst(40);
      steady = (p == 1);
      random_burst(40);
      steady = 1'b0;
      wait_drained();
    end
  endtask

  task automatic test_drain_pause;
    random_burst(15);
    // hold the sender until every beat of the backlog has gone out
    wait_drained();
    random_burst(15);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", int'(m_tdata), -1);
      end else begin
        want = pending_beats.pop_front();
        if (m_tuser !== want.rs) report_mismatch("register_select", int'(m_tuser), int'(want.rs));
        if (m_tdata[3:0] !== want.nib) report_mismatch("nibble", int'(m_tdata[3:0]), int'(want.nib));
        if (m_tdata[5:4] !== want.settle) begin
          report_mismatch("settle_class", int'(m_tdata[5:4]), int'(want.settle));
        end
        if (m_tlast !== want.last) report_mismatch("last", int'(m_tlast), int'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cursor_addr = '0;
    mismatches  = 0;
    cycles      = 0;
    steady      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    apb_check_cursor();
    test_setup_sequence();
    test_sample_extremes();
    test_cursor_address();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- decimal_reading_lcd_nibble_writer_top.f -----
rtl/core/drlw_pkg.sv
rtl/core/drlw_front.sv
rtl/core/drlw_fifo.sv
rtl/core/drlw_back.sv
rtl/core/decimal_reading_lcd_nibble_writer_top.sv
sim/testbench.sv
